// ===== rtl/core/lbf_pkg.sv =====
// Shared types and constants of the LED bar frame controller.
`default_nettype none

package lbf_pkg;

	localparam int CMD_W    = 3;
	localparam int MASK_W   = 10;
	localparam int BRIGHT_W = 40;
	localparam int LEVEL_W  = 4;
	localparam int INTEN_W  = 2;
	localparam int DIR_W    = 2;
	localparam int WORD_W   = 10;
	localparam int BYTE_W   = 8;
	localparam int IN_BYTES = 5;

	typedef logic [BYTE_W-1:0] byte_t;

	localparam byte_t BYTE_FULL = 8'hFF;
	localparam byte_t BYTE_MED  = 8'hAA;
	localparam byte_t BYTE_DIM  = 8'h01;
	localparam byte_t BYTE_OFF  = 8'h00;
	localparam byte_t CMD_WORD  = 8'h00;
	localparam byte_t PAD_WORD  = 8'h00;

	localparam logic KIND_FRAME = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	localparam logic [INTEN_W-1:0] INTEN_DIM  = 2'd1;
	localparam logic [INTEN_W-1:0] INTEN_MED  = 2'd2;
	localparam logic [INTEN_W-1:0] INTEN_FULL = 2'd3;

	localparam logic [DIR_W-1:0] DIR_FROM_FIRST = 2'd0;
	localparam logic [DIR_W-1:0] DIR_FROM_LAST  = 2'd1;

	typedef enum logic [CMD_W-1:0] {
		CMD_RESET      = 3'd0,
		CMD_WRITE_MASK = 3'd1,
		CMD_SET_BRIGHT = 3'd2,
		CMD_SET_LEVEL  = 3'd3,
		CMD_READ       = 3'd4
	} cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_FRAME
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic apply;
		logic clr_cnt;
		logic load_word;
		logic load_read;
	} ctrl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
		logic cnt_last;
	} stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/lbf_if.sv =====
// Handshake interfaces for the command and result channels.
`default_nettype none

interface lbf_in_if import lbf_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    cmd;
	logic [MASK_W-1:0]   led_mask;
	logic [BRIGHT_W-1:0] bright_low;
	logic [BRIGHT_W-1:0] bright_high;
	logic [LEVEL_W-1:0]  bar_level;
	logic [INTEN_W-1:0]  intensity;
	logic [DIR_W-1:0]    direction;

	modport source (
		output valid, cmd, led_mask, bright_low, bright_high, bar_level, intensity,
			direction,
		input  ready
	);
	modport sink (
		input  valid, cmd, led_mask, bright_low, bright_high, bar_level, intensity,
			direction,
		output ready
	);
endinterface

interface lbf_out_if import lbf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              kind;
	logic [WORD_W-1:0] word;
	logic              last;

	modport source (output valid, kind, word, last, input ready);
	modport sink (input valid, kind, word, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lbf_ctrl.sv =====
// Controller state machine: command acceptance and frame sequencing.
`default_nettype none

module lbf_ctrl import lbf_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic [CMD_W-1:0] in_cmd,
	output logic                  in_ready,
	input  wire stat_t            stat,
	output ctrl_t                 ctrl
);

	state_t state_q;
	state_t state_nxt;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE) && stat.out_free;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd_t'(in_cmd))
						CMD_RESET, CMD_WRITE_MASK, CMD_SET_BRIGHT, CMD_SET_LEVEL: begin
							state_nxt = ST_FRAME;
						end
						default: begin
							state_nxt = ST_IDLE;
						end
					endcase
				end
			end
			ST_FRAME: begin
				if (stat.out_free && stat.cnt_last) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctrl = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd_t'(in_cmd))
						CMD_RESET, CMD_WRITE_MASK, CMD_SET_BRIGHT, CMD_SET_LEVEL: begin
							ctrl.apply   = 1'b1;
							ctrl.clr_cnt = 1'b1;
						end
						CMD_READ: begin
							ctrl.load_read = 1'b1;
						end
						default: begin
							// Unused codes are taken and dropped.
							ctrl = '0;
						end
					endcase
				end
			end
			ST_FRAME: begin
				ctrl.load_word = stat.out_free;
			end
			default: begin
				ctrl = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/lbf_datapath.sv =====
// Datapath: brightness store, frame word counter and output register.
`default_nettype none

module lbf_datapath import lbf_pkg::*; #(
	parameter int NUM_LEDS = 10
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ctrl_t               ctrl,
	output stat_t                    stat,
	input  wire logic [CMD_W-1:0]    cmd,
	input  wire logic [MASK_W-1:0]   led_mask,
	input  wire logic [BRIGHT_W-1:0] bright_low,
	input  wire logic [BRIGHT_W-1:0] bright_high,
	input  wire logic [LEVEL_W-1:0]  bar_level,
	input  wire logic [INTEN_W-1:0]  intensity,
	input  wire logic [DIR_W-1:0]    direction,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic                     out_kind,
	output logic [WORD_W-1:0]        out_word,
	output logic                     out_last
);

	localparam int CW        = $clog2(NUM_LEDS + 3);
	localparam int LEVEL_CAP = (NUM_LEDS < 15) ? NUM_LEDS : 15;

	byte_t               bright_q [NUM_LEDS];
	byte_t               bright_nxt [NUM_LEDS];
	logic [CW-1:0]       cnt_q;
	logic                out_valid_q;
	logic                out_kind_q;
	logic [WORD_W-1:0]   out_word_q;
	logic                out_last_q;
	logic [LEVEL_W-1:0]  lvl_sat;
	byte_t               level_byte;
	byte_t               frame_byte;
	logic [WORD_W-1:0]   read_map;

	assign lvl_sat = (bar_level > LEVEL_W'(LEVEL_CAP)) ? LEVEL_W'(LEVEL_CAP) : bar_level;

	always_comb begin
		case (intensity)
			INTEN_DIM:  level_byte = BYTE_DIM;
			INTEN_MED:  level_byte = BYTE_MED;
			INTEN_FULL: level_byte = BYTE_FULL;
			default:    level_byte = BYTE_OFF;
		endcase
	end

	// New brightness of every LED for the command being applied.
	for (genvar g = 0; g < NUM_LEDS; g++) begin : g_led
		logic  en;
		byte_t in_byte;
		logic  lit;

		if (g < IN_BYTES) begin : g_low
			assign en      = led_mask[g];
			assign in_byte = bright_low[BYTE_W*g +: BYTE_W];
		end else if (g < 2 * IN_BYTES) begin : g_high
			assign en      = led_mask[g];
			assign in_byte = bright_high[BYTE_W*(g-IN_BYTES) +: BYTE_W];
		end else begin : g_none
			assign en      = 1'b0;
			assign in_byte = BYTE_OFF;
		end

		always_comb begin
			if (direction == DIR_FROM_FIRST) begin
				lit = g < int'(lvl_sat);
			end else if (direction == DIR_FROM_LAST) begin
				lit = g >= NUM_LEDS - int'(lvl_sat);
			end else begin
				lit = 1'b0;
			end
		end

		always_comb begin
			bright_nxt[g] = BYTE_OFF;
			case (cmd_t'(cmd))
				CMD_WRITE_MASK: if (en) bright_nxt[g] = BYTE_FULL;
				CMD_SET_BRIGHT: if (en) bright_nxt[g] = in_byte;
				CMD_SET_LEVEL:  if (lit) bright_nxt[g] = level_byte;
				default:        bright_nxt[g] = BYTE_OFF;
			endcase
		end
	end

	// Bitmap of lit LEDs; only the first WORD_W LEDs are reported.
	for (genvar g = 0; g < WORD_W; g++) begin : g_map
		if (g < NUM_LEDS) begin : g_on
			assign read_map[g] = |bright_q[g];
		end else begin : g_off
			assign read_map[g] = 1'b0;
		end
	end

	// Word 0 is the command word, then one byte per LED, then the pad words.
	always_comb begin
		frame_byte = PAD_WORD;
		if (cnt_q == '0) begin
			frame_byte = CMD_WORD;
		end
		for (int i = 0; i < NUM_LEDS; i++) begin
			if (cnt_q == CW'(i + 1)) begin
				frame_byte = bright_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEDS; i++) begin
				bright_q[i] <= BYTE_OFF;
			end
		end else if (ctrl.apply) begin
			bright_q <= bright_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.clr_cnt) begin
				cnt_q <= '0;
			end else if (ctrl.load_word) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (ctrl.load_word || ctrl.load_read) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_word) begin
			out_kind_q <= KIND_FRAME;
			out_word_q <= {{(WORD_W - BYTE_W){1'b0}}, frame_byte};
			out_last_q <= stat.cnt_last;
		end else if (ctrl.load_read) begin
			out_kind_q <= KIND_READ;
			out_word_q <= read_map;
			out_last_q <= 1'b1;
		end
	end

	assign stat.out_free = !out_valid_q || out_ready;
	assign stat.cnt_last = (cnt_q == CW'(NUM_LEDS + 2));

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_word  = out_word_q;
	assign out_last  = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/core/led_bar_frame_controller_unit.sv =====
// Top level of the LED bar frame controller.
// The block keeps one brightness byte per LED and answers each command item on req. Reset,
// write mask, set brightness and set level update the store in the cycle the item is taken
// and then send a frame of NUM_LEDS+3 words on rsp, one word per cycle while rsp is ready:
// a zero command word, the LED bytes from LED 0 upward, and two zero pad words, the last
// one flagged with last, and takes no new item until the frame is sent. The word counter
// walks the frame through the single output register. A read item returns one word with
// the bitmap of lit LEDs; command codes five to seven are taken and produce nothing.
`default_nettype none

module led_bar_frame_controller_unit import lbf_pkg::*; #(
	parameter int NUM_LEDS = 10
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	lbf_in_if.sink     req,
	lbf_out_if.source  rsp
);

	ctrl_t ctrl;
	stat_t stat;

	lbf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_cmd   (req.cmd),
		.in_ready (req.ready),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	lbf_datapath #(
		.NUM_LEDS (NUM_LEDS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.stat        (stat),
		.cmd         (req.cmd),
		.led_mask    (req.led_mask),
		.bright_low  (req.bright_low),
		.bright_high (req.bright_high),
		.bar_level   (req.bar_level),
		.intensity   (req.intensity),
		.direction   (req.direction),
		.out_valid   (rsp.valid),
		.out_ready   (rsp.ready),
		.out_kind    (rsp.kind),
		.out_word    (rsp.word),
		.out_last    (rsp.last)
	);

endmodule

`default_nettype wire

// ===== rtl/core/lbf_checker.sv =====
// Port-level checks of the LED bar frame controller and their binding.
`default_nettype none

module lbf_checker import lbf_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic [CMD_W-1:0]  in_cmd,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic              out_kind,
	input wire logic [WORD_W-1:0] out_word,
	input wire logic              out_last
);

	logic in_acc;
	logic frame_cmd;

	assign in_acc    = in_valid && in_ready;
	assign frame_cmd = (in_cmd == CMD_RESET) || (in_cmd == CMD_WRITE_MASK) ||
		(in_cmd == CMD_SET_BRIGHT) || (in_cmd == CMD_SET_LEVEL);

	// A stalled result item keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			out_valid && $stable(out_kind) && $stable(out_word) && $stable(out_last))
		else $error("result item changed while stalled");

	// No new command is taken right after a frame command.
	a_frame_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && frame_cmd |=> !in_ready)
		else $error("command taken while a frame is being sent");

	// A read produces its response in the next cycle.
	a_read_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (in_cmd == CMD_READ) |=> out_valid && (out_kind == KIND_READ) && out_last)
		else $error("read response missing");

	// A read response is always a single, final item.
	a_read_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind == KIND_READ) |-> out_last)
		else $error("read response without last");

endmodule

bind led_bar_frame_controller_unit lbf_checker u_lbf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (req.valid),
	.in_ready  (req.ready),
	.in_cmd    (req.cmd),
	.out_valid (rsp.valid),
	.out_ready (rsp.ready),
	.out_kind  (rsp.kind),
	.out_word  (rsp.word),
	.out_last  (rsp.last)
);

`default_nettype wire

// ===== tb/tb_led_bar_frame_controller_unit.sv =====
// Self-checking testbench of the LED bar frame controller: a directed table, then random commands.
`timescale 1ns / 100ps

module tb_led_bar_frame_controller_unit;
	import lbf_pkg::*;

	localparam int LEDS        = 10;
	localparam int PER_PHASE   = 48;
	localparam int DRAIN       = 4 * (LEDS + 4);
	localparam int STALL_LIMIT = 5000;
	localparam int REPORT_MAX  = 100;
	localparam int PLAN_ROWS   = 27;

	localparam logic [CMD_W-1:0]    CMD_SPARE_LO = 3'd5;
	localparam logic [CMD_W-1:0]    CMD_SPARE_HI = 3'd7;
	localparam logic [INTEN_W-1:0]  INTEN_OFF    = 2'd0;
	localparam logic [DIR_W-1:0]    DIR_BLANK_LO = 2'd2;
	localparam logic [DIR_W-1:0]    DIR_BLANK_HI = 2'd3;
	localparam logic [MASK_W-1:0]   NO_LEDS      = '0;
	localparam logic [MASK_W-1:0]   ALL_LEDS     = '1;
	localparam logic [BRIGHT_W-1:0] DARK         = '0;
	localparam logic [BRIGHT_W-1:0] BLAZE        = '1;

	typedef struct packed {
		logic [CMD_W-1:0]    cmd;
		logic [MASK_W-1:0]   led_mask;
		logic [BRIGHT_W-1:0] bright_low;
		logic [BRIGHT_W-1:0] bright_high;
		logic [LEVEL_W-1:0]  bar_level;
		logic [INTEN_W-1:0]  intensity;
		logic [DIR_W-1:0]    direction;
	} command_t;

	typedef struct packed {
		logic              kind;
		logic [WORD_W-1:0] word;
		logic              last;
	} out_word_t;

	// A row with typed set carries its expected result: for a frame the byte that every
	// LED must show, for a read the bitmap.
	typedef struct packed {
		command_t          item;
		logic              typed;
		logic [WORD_W-1:0] typed_word;
	} plan_row_t;

	logic clk;
	logic arst_n;

	lbf_in_if  req ();
	lbf_out_if rsp ();

	led_bar_frame_controller_unit #(.NUM_LEDS(LEDS)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	byte_t     led_level [LEDS];
	out_word_t due_words [$];
	int        errors         = 0;
	int        words_checked  = 0;
	int        frames_sent    = 0;
	int        reads_sent     = 0;
	int        ignored_sent   = 0;
	int        quiet_cycles   = 0;
	int        send_idle_pct  = 0;
	int        recv_stall_pct = 0;

	plan_row_t plan [PLAN_ROWS] = '{
		'{'{CMD_READ, NO_LEDS, DARK, DARK, 4'd0, INTEN_OFF, DIR_FROM_FIRST}, 1'b1, 10'h000},
		'{'{CMD_RESET, ALL_LEDS, BLAZE, BLAZE, 4'd15, INTEN_FULL, DIR_BLANK_HI}, 1'b1, 10'h000},
		'{'{CMD_WRITE_MASK, ALL_LEDS, DARK, DARK, 4'd0, INTEN_OFF, DIR_FROM_FIRST}, 1'b1, 10'h0FF},
		'{'{CMD_READ, NO_LEDS, DARK, DARK, 4'd0, INTEN_OFF, DIR_FROM_FIRST}, 1'b1, 10'h3FF},
		'{'{CMD_WRITE_MASK, NO_LEDS, BLAZE, BLAZE, 4'd10, INTEN_FULL, DIR_FROM_FIRST}, 1'b1, 10'h000},
		'{'{CMD_WRITE_MASK, 10'h155, DARK, DARK, 4'd0, INTEN_OFF, DIR_FROM_FIRST}, 1'b0, 10'h000},
		'{'{CMD_SET_BRIGHT, ALL_LEDS, BLAZE, BLAZE, 4'd0, INTEN_OFF, DIR_FROM_FIRST}, 1'b1, 10'h0FF},
		'{'{CMD_SET_BRIGHT, 10'h2AA, 40'h05_04_03_02_01, 40'h0A_09_08_07_06, 4'd0, INTEN_OFF,
			DIR_FROM_FIRST}, 1'b0, 10'h000},
		'{'{CMD_READ, NO_LEDS, DARK, DARK, 4'd0, INTEN_OFF, DIR_FROM_FIRST}, 1'b0, 10'h000},
		'{'{CMD_SET_BRIGHT, ALL_LEDS, 40'h80_00_7F_00_01, 40'h00_FE_00_40_00, 4'd0, INTEN_OFF,
			DIR_FROM_FIRST}, 1'b0, 10'h000},
		'{'{CMD_READ, NO_LEDS, DARK, DARK, 4'd0, INTEN_OFF, DIR_FROM_FIRST}, 1'b0, 10'h000},
		'{'{CMD_SET_BRIGHT, NO_LEDS, BLAZE, BLAZE, 4'd0, INTEN_OFF, DIR_FROM_FIRST}, 1'b1, 10'h000},
		'{'{CMD_SET_LEVEL, NO_LEDS, DARK, DARK, 4'd10, INTEN_FULL, DIR_FROM_FIRST}, 1'b1, 10'h0FF},
		'{'{CMD_SET_LEVEL, NO_LEDS, DARK, DARK, 4'd15, INTEN_DIM, DIR_FROM_LAST}, 1'b1, 10'h001},
		'{'{CMD_READ, NO_LEDS, DARK, DARK, 4'd0, INTEN_OFF, DIR_FROM_FIRST}, 1'b1, 10'h3FF},
		'{'{CMD_SET_LEVEL, NO_LEDS, DARK, DARK, 4'd0, INTEN_FULL, DIR_FROM_FIRST}, 1'b1, 10'h000},
		'{'{CMD_SET_LEVEL, NO_LEDS, DARK, DARK, 4'd4, INTEN_MED, DIR_FROM_FIRST}, 1'b0, 10'h000},
		'{'{CMD_READ, NO_LEDS, DARK, DARK, 4'd0, INTEN_OFF, DIR_FROM_FIRST}, 1'b0, 10'h000},
		'{'{CMD_SET_LEVEL, ALL_LEDS, BLAZE, BLAZE, 4'd3, INTEN_FULL, DIR_FROM_LAST}, 1'b0, 10'h000},
		'{'{CMD_SET_LEVEL, NO_LEDS, DARK, DARK, 4'd7, INTEN_OFF, DIR_FROM_FIRST}, 1'b1, 10'h000},
		'{'{CMD_WRITE_MASK, 10'h0F0, DARK, DARK, 4'd0, INTEN_OFF, DIR_FROM_FIRST}, 1'b0, 10'h000},
		'{'{CMD_SET_LEVEL, NO_LEDS, DARK, DARK, 4'd10, INTEN_FULL, DIR_BLANK_LO}, 1'b1, 10'h000},
		'{'{CMD_WRITE_MASK, ALL_LEDS, DARK, DARK, 4'd0, INTEN_OFF, DIR_FROM_FIRST}, 1'b0, 10'h000},
		'{'{CMD_SPARE_HI, ALL_LEDS, BLAZE, BLAZE, 4'd15, INTEN_FULL, DIR_BLANK_HI}, 1'b0, 10'h000},
		'{'{CMD_SPARE_LO, NO_LEDS, DARK, DARK, 4'd0, INTEN_OFF, DIR_FROM_FIRST}, 1'b0, 10'h000},
		'{'{CMD_READ, NO_LEDS, DARK, DARK, 4'd0, INTEN_OFF, DIR_FROM_FIRST}, 1'b1, 10'h3FF},
		'{'{CMD_SET_LEVEL, NO_LEDS, DARK, DARK, 4'd10, INTEN_FULL, DIR_BLANK_HI}, 1'b1, 10'h000}
	};

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic push_frame(input byte_t levels [LEDS]);
		int i;
		due_words.push_back('{KIND_FRAME, WORD_W'(CMD_WORD), 1'b0});
		for (i = 0; i < LEDS; i++)
			due_words.push_back('{KIND_FRAME, WORD_W'(levels[i]), 1'b0});
		due_words.push_back('{KIND_FRAME, WORD_W'(PAD_WORD), 1'b0});
		due_words.push_back('{KIND_FRAME, WORD_W'(PAD_WORD), 1'b1});
	endtask

	// Updates the LED store for one command and, if asked, queues the words it produces.
	task automatic apply_command(input command_t c, input logic queue_it);
		int                i;
		int                span;
		byte_t             fill;
		logic              lit;
		logic [MASK_W-1:0] lit_map;
		case (c.cmd)
			CMD_RESET: begin
				for (i = 0; i < LEDS; i++)
					led_level[i] = BYTE_OFF;
			end
			CMD_WRITE_MASK: begin
				for (i = 0; i < LEDS; i++)
					led_level[i] = c.led_mask[i] ? BYTE_FULL : BYTE_OFF;
			end
			CMD_SET_BRIGHT: begin
				for (i = 0; i < LEDS; i++) begin
					if (!c.led_mask[i])
						led_level[i] = BYTE_OFF;
					else if (i < IN_BYTES)
						led_level[i] = c.bright_low[BYTE_W*i +: BYTE_W];
					else
						led_level[i] = c.bright_high[BYTE_W*(i-IN_BYTES) +: BYTE_W];
				end
			end
			CMD_SET_LEVEL: begin
				span = (c.bar_level > LEDS) ? LEDS : int'(c.bar_level);
				case (c.intensity)
					INTEN_DIM:  fill = BYTE_DIM;
					INTEN_MED:  fill = BYTE_MED;
					INTEN_FULL: fill = BYTE_FULL;
					default:    fill = BYTE_OFF;
				endcase
				for (i = 0; i < LEDS; i++) begin
					if (c.direction == DIR_FROM_FIRST)
						lit = i < span;
					else if (c.direction == DIR_FROM_LAST)
						lit = i >= LEDS - span;
					else
						lit = 1'b0;
					led_level[i] = lit ? fill : BYTE_OFF;
				end
			end
			CMD_READ: begin
				lit_map = '0;
				for (i = 0; i < LEDS; i++)
					lit_map[i] = led_level[i] != BYTE_OFF;
				reads_sent++;
				if (queue_it)
					due_words.push_back('{KIND_READ, lit_map, 1'b1});
				return;
			end
			default: begin
				ignored_sent++;
				return;
			end
		endcase
		frames_sent++;
		if (queue_it)
			push_frame(led_level);
	endtask

	// Offers one item on req after an optional idle gap and books its results once taken.
	task automatic issue(input command_t c, input logic typed, input logic [WORD_W-1:0] typed_word);
		byte_t uniform [LEDS];
		int    i;
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid    <= 1'b0;
			req.cmd      <= CMD_W'($urandom);
			req.led_mask <= MASK_W'($urandom);
			@(posedge clk);
		end
		req.valid       <= 1'b1;
		req.cmd         <= c.cmd;
		req.led_mask    <= c.led_mask;
		req.bright_low  <= c.bright_low;
		req.bright_high <= c.bright_high;
		req.bar_level   <= c.bar_level;
		req.intensity   <= c.intensity;
		req.direction   <= c.direction;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		apply_command(c, !typed);
		if (typed) begin
			if (c.cmd == CMD_READ) begin
				due_words.push_back('{KIND_READ, typed_word, 1'b1});
			end else begin
				for (i = 0; i < LEDS; i++)
					uniform[i] = typed_word[BYTE_W-1:0];
				push_frame(uniform);
			end
		end
	endtask

	function automatic command_t random_command();
		command_t c;
		int       pick;
		int       i;
		pick = $urandom_range(99);
		if (pick < 5)
			c.cmd = CMD_RESET;
		else if (pick < 25)
			c.cmd = CMD_WRITE_MASK;
		else if (pick < 50)
			c.cmd = CMD_SET_BRIGHT;
		else if (pick < 75)
			c.cmd = CMD_SET_LEVEL;
		else if (pick < 95)
			c.cmd = CMD_READ;
		else
			c.cmd = CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
		case ($urandom_range(7))
			0:       c.led_mask = NO_LEDS;
			1:       c.led_mask = ALL_LEDS;
			default: c.led_mask = MASK_W'($urandom);
		endcase
		// Zero bytes are frequent so that the read bitmap sees dark LEDs under the mask.
		for (i = 0; i < IN_BYTES; i++) begin
			c.bright_low[BYTE_W*i +: BYTE_W] =
				($urandom_range(3) == 0) ? BYTE_OFF : BYTE_W'($urandom);
			c.bright_high[BYTE_W*i +: BYTE_W] =
				($urandom_range(3) == 0) ? BYTE_OFF : BYTE_W'($urandom);
		end
		c.bar_level = ($urandom_range(3) == 0) ? LEVEL_W'($urandom) : LEVEL_W'($urandom_range(LEDS));
		c.intensity = INTEN_W'($urandom);
		c.direction = ($urandom_range(3) == 0) ?
			DIR_W'($urandom_range(DIR_BLANK_HI, DIR_BLANK_LO)) :
			DIR_W'($urandom_range(DIR_FROM_LAST, DIR_FROM_FIRST));
		return c;
	endfunction

	always @(posedge clk) begin : check_words
		out_word_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			words_checked++;
			if (due_words.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("%0t: expected no word, got kind=%0d word=%h last=%0d",
						$time, rsp.kind, rsp.word, rsp.last);
			end else begin
				want = due_words.pop_front();
				if (rsp.kind !== want.kind || rsp.word !== want.word || rsp.last !== want.last) begin
					errors++;
					if (errors <= REPORT_MAX)
						$display("%0t: expected kind=%0d word=%h last=%0d, got kind=%0d word=%h last=%0d",
							$time, want.kind, want.word, want.last, rsp.kind, rsp.word, rsp.last);
				end
			end
		end
	end

	always @(posedge clk) begin
		rsp.ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no item moved for %0d cycles, %0d words still due",
				$time, quiet_cycles, due_words.size());
			$display("tb_led_bar_frame_controller_unit: errors");
			$finish;
		end
	end

	initial begin : stimulus
		command_t c;
		int       counted;
		int       phase;
		int       i;
		arst_n          = 1'b0;
		req.valid       = 1'b0;
		req.cmd         = CMD_RESET;
		req.led_mask    = NO_LEDS;
		req.bright_low  = DARK;
		req.bright_high = DARK;
		req.bar_level   = '0;
		req.intensity   = INTEN_OFF;
		req.direction   = DIR_FROM_FIRST;
		rsp.ready       = 1'b0;
		for (i = 0; i < LEDS; i++)
			led_level[i] = BYTE_OFF;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[r])
			issue(plan[r].item, plan[r].typed, plan[r].typed_word);

		// Idle mixes: none, sender gaps, receiver stalls, then light gaps on both sides.
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 67;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 67;
				end
				default: begin
					send_idle_pct  = 12;
					recv_stall_pct = 12;
				end
			endcase
			counted = 0;
			while (counted < PER_PHASE) begin
				c = random_command();
				issue(c, 1'b0, '0);
				if (c.cmd <= CMD_READ)
					counted++;
			end
		end
		req.valid <= 1'b0;

		while (due_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("Ran %0d directed rows and %0d random commands over four idle mixes.",
			PLAN_ROWS, 4 * PER_PHASE);
		$display("Commands: %0d frames, %0d reads, %0d unused codes; %0d words checked, %0d bad.",
			frames_sent, reads_sent, ignored_sent, words_checked, errors);
		if (errors == 0)
			$display("tb_led_bar_frame_controller_unit: clean");
		else
			$display("tb_led_bar_frame_controller_unit: errors");
		$finish;
	end

endmodule
